@@ rtl/posting_list_varbyte_decoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Posting list decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSTING_LIST_VARBYTE_DECODER_UNIT_MACROS_SVH
`define POSTING_LIST_VARBYTE_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define PLVD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plvd assertion failed");

// next-cycle implication
`define PLVD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plvd assertion failed");

`endif

@@ rtl/plvd_pkg.sv @@
// ----------------------------------------------------------------------------
// plvd_pkg
// Types and constants of the variable-byte posting list decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package plvd_pkg;

	localparam int ACC_W      = 64;  // decoded value width
	localparam int GROUP_BITS = 7;   // payload bits per code byte
	localparam int BYTE_W     = 8;
	localparam int END_BIT    = 7;   // end-of-value mark in code byte
	localparam int OFF_W      = 7;   // bit offset, saturates above ACC_W

	// offsets at or past this point only drop bits
	localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(ACC_W);
	// offsets above this point straddle the top of the accumulator
	localparam logic [OFF_W-1:0] OFF_EDGE  = OFF_W'(ACC_W - GROUP_BITS);
	localparam logic [OFF_W-1:0] OFF_STEP  = OFF_W'(GROUP_BITS);

	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              list_last;
	} code_t;

	typedef struct packed {
		logic [ACC_W-1:0] doc_index;
		logic [ACC_W-1:0] term_count;
		logic             list_end;
		logic             overflow;
	} pair_t;

	// decoder status, watched at the top level
	typedef struct packed {
		logic             expecting;
		logic [OFF_W-1:0] offset;
	} stat_t;

endpackage

`default_nettype wire

@@ rtl/plvd_code_if.sv @@
// ----------------------------------------------------------------------------
// plvd_code_if
// Input channel: one code byte of a posting list per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface plvd_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       list_last;

	modport source (output valid, output code_byte, output list_last, input ready);
	modport sink   (input valid, input code_byte, input list_last, output ready);
endinterface

`default_nettype wire

@@ rtl/plvd_pair_if.sv @@
// ----------------------------------------------------------------------------
// plvd_pair_if
// Output channel: one decoded (document, count) pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface plvd_pair_if;
	logic        valid;
	logic        ready;
	logic [63:0] doc_index;
	logic [63:0] term_count;
	logic        list_end;
	logic        overflow;

	modport source (output valid, output doc_index, output term_count,
		output list_end, output overflow, input ready);
	modport sink   (input valid, input doc_index, input term_count,
		input list_end, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/plvd_in_stage.sv @@
// ----------------------------------------------------------------------------
// plvd_in_stage
// Input register: holds one code byte until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module plvd_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire plvd_pkg::code_t in_item,
	output logic                valid_s1,
	output plvd_pkg::code_t     item_s1,
	input  wire logic           take
);
	import plvd_pkg::*;

	logic load;

	assign in_ready = !valid_s1 || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ rtl/plvd_core.sv @@
// ----------------------------------------------------------------------------
// plvd_core
// Decoder state and single-cycle step: gathers payload groups, closes
// values and forms (document, count) pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module plvd_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s1,
	input  wire plvd_pkg::code_t item_s1,
	input  wire logic            out_free,
	output logic                 take,
	output logic                 emit,
	output plvd_pkg::pair_t      pair,
	output plvd_pkg::stat_t      stat
);
	import plvd_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [OFF_W-1:0] off_q;
	logic             expecting_q;
	logic [ACC_W-1:0] held_q;
	logic             lost_q;

	logic [ACC_W-1:0] payload;
	logic [ACC_W-1:0] acc_n;
	logic [OFF_W-1:0] top_shift;
	logic             lost_n;
	logic             done;
	logic             last;

	assign last    = item_s1.list_last;
	assign done    = item_s1.code_byte[END_BIT] || last;
	assign payload = ACC_W'(item_s1.code_byte[GROUP_BITS-1:0]);

	// distance to the top of the accumulator, used only when off_q > OFF_EDGE
	assign top_shift = OFF_LIMIT - off_q;

	always_comb begin
		acc_n  = acc_q;
		lost_n = lost_q;
		if (off_q < OFF_LIMIT) begin
			acc_n = acc_q | (payload << off_q[OFF_W-2:0]);
			if (off_q > OFF_EDGE && (payload >> top_shift) != '0) begin
				lost_n = 1'b1;
			end
		end else if (payload != '0) begin
			lost_n = 1'b1;
		end
	end

	// a result appears when a count closes, or when the list ends
	assign emit = done && (expecting_q || last);
	assign take = valid_s1 && (!emit || out_free);

	always_comb begin
		pair.doc_index  = expecting_q ? held_q : acc_n;
		pair.term_count = expecting_q ? acc_n : '0;
		pair.list_end   = last;
		pair.overflow   = lost_n;
	end

	assign stat.expecting = expecting_q;
	assign stat.offset    = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			off_q       <= '0;
			expecting_q <= 1'b0;
			held_q      <= '0;
			lost_q      <= 1'b0;
		end else if (take) begin
			if (!done) begin
				acc_q  <= acc_n;
				lost_q <= lost_n;
				if (off_q < OFF_LIMIT) begin
					off_q <= off_q + OFF_STEP;
				end
			end else begin
				acc_q <= '0;
				off_q <= '0;
				if (emit) begin
					expecting_q <= 1'b0;
					held_q      <= '0;
					lost_q      <= 1'b0;
				end else begin
					// index closed, wait for its count
					expecting_q <= 1'b1;
					held_q      <= acc_n;
					lost_q      <= lost_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/plvd_out_stage.sv @@
// ----------------------------------------------------------------------------
// plvd_out_stage
// Result register: holds one pair until the sink takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module plvd_out_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire plvd_pkg::pair_t pair_in,
	output logic                 out_free,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output plvd_pkg::pair_t      pair_q
);
	import plvd_pkg::*;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pair_q <= pair_in;
		end
	end

endmodule

`default_nettype wire

@@ rtl/posting_list_varbyte_decoder_unit.sv @@
// A closing byte is held in the input register, its pair in the result register.
// Throughput: one byte per cycle unless stalled; the decoder state update is one
//   register-to-register step (shift and OR into the 64-bit accumulator).
// Bytes that close no pair pass even while the result register is stalled.
// Reset (arst_n low, asynchronous): both channels empty, decoder expects an index.
// ----------------------------------------------------------------------------
// posting_list_varbyte_decoder_unit
// Variable-byte posting list decoder: code bytes in, (document, count) pairs out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "posting_list_varbyte_decoder_unit_macros.svh"

module posting_list_varbyte_decoder_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	plvd_code_if.sink   code,
	plvd_pair_if.source pair
);
	import plvd_pkg::*;

	code_t in_item;
	code_t item_s1;
	logic  valid_s1;
	logic  take;
	logic  emit;
	logic  out_free;
	pair_t pair_n;
	pair_t pair_q;
	stat_t stat;

	assign in_item.code_byte = code.code_byte;
	assign in_item.list_last = code.list_last;

	plvd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (code.valid),
		.in_ready (code.ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take)
	);

	plvd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.take     (take),
		.emit     (emit),
		.pair     (pair_n),
		.stat     (stat)
	);

	plvd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && emit),
		.pair_in   (pair_n),
		.out_free  (out_free),
		.out_valid (pair.valid),
		.out_ready (pair.ready),
		.pair_q    (pair_q)
	);

	assign pair.doc_index  = pair_q.doc_index;
	assign pair.term_count = pair_q.term_count;
	assign pair.list_end   = pair_q.list_end;
	assign pair.overflow   = pair_q.overflow;

	// input stalls only behind a held byte
	`PLVD_ASSERT_IMPL(a_stall_has_item, !code.ready, valid_s1)
	// offset never runs past one group above the accumulator
	`PLVD_ASSERT_IMPL(a_offset_range, 1'b1, stat.offset <= OFF_LIMIT + OFF_STEP - 7'd1)
	// an emitted pair leaves the decoder waiting for a fresh index
	`PLVD_ASSERT_NEXT(a_emit_clears, take && emit, !stat.expecting && stat.offset == '0)
	// an emitted pair is on the output the next cycle
	`PLVD_ASSERT_NEXT(a_emit_shows, take && emit, pair.valid)

endmodule

`default_nettype wire
